[hdl/obs_pkg.sv]
// ----------------------------------------------------------------------------
// Order book slippage engine package
// Shared widths, command and status codes, controller states and the
// request/response structs of the fill-price divider.
// ----------------------------------------------------------------------------
package obs_pkg;

   localparam int MAX_LEVELS_DEF = 64;
   localparam int PRICE_W        = 32;
   localparam int QTY_W          = 32;
   localparam int LVL_W          = PRICE_W + QTY_W;
   localparam int FRAC_W         = 16;
   localparam int SLIP_W         = 49;
   localparam int WIDE_W         = 33;
   localparam int ACC_W          = 64;
   localparam int DVD_W          = ACC_W + FRAC_W;
   localparam int CMD_W          = 2;
   localparam int STATUS_W       = 3;
   localparam int REQ_DATA_W     = 64;
   localparam int RSP_DATA_W     = 184;
   localparam int RSP_USED_W     = 2 * PRICE_W + 2 * WIDE_W + SLIP_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_ADD_BID = 2'd1,
      CMD_ADD_ASK = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_SHORT    = 3'd2,
      ST_ZERO_QTY = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_EV,
      S_INS_WR,
      S_Q_RD,
      S_Q_EV,
      S_Q_END,
      S_Q_CHK,
      S_DIV,
      S_RESP
   } state_type;

   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] weighted;
      logic [QTY_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SLIP_W-1:0] quotient;
   } div_rsp_type;

endpackage

[hdl/obs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module obs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/obs_div.sv]
// ----------------------------------------------------------------------------
// Fill-price divider
// Restoring radix-2 divider: (weighted << 16) / quantity, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module obs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  obs_pkg::div_req_type div_req,
   output obs_pkg::div_rsp_type div_rsp
);
   import obs_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dq_ff;
   logic [QTY_W-1:0] rem_ff;
   logic [QTY_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [QTY_W:0]   trial;
   logic             ge;
   logic [QTY_W:0]   diff;
   logic [QTY_W-1:0] rem_in;
   logic [DVD_W-1:0] dq_in;

   // partial remainder stays below the divisor, so the trial fits 33 bits
   always_comb begin
      trial  = {rem_ff, dq_ff[DVD_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      rem_in = ge ? diff[QTY_W-1:0] : trial[QTY_W-1:0];
      dq_in  = {dq_ff[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (cnt_ff == CNT_W'(1));
         if (div_req.start) begin
            dq_ff   <= {div_req.weighted, {FRAC_W{1'b0}}};
            rem_ff  <= '0;
            dvs_ff  <= div_req.divisor;
            cnt_ff  <= CNT_W'(DVD_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dq_ff  <= dq_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff[SLIP_W-1:0];

endmodule

[hdl/order_book_slippage_engine.sv]
// ----------------------------------------------------------------------------
// Order book slippage engine
// Sorted bid/ask ladders in RAM, level insert, and VWAP slippage query.
// ----------------------------------------------------------------------------
// Each request returns one response describing the book after the request.
// Ladders live in two RAMs (one read, one write per cycle, registered read
// data). Clear, side-full, empty-side and zero-quantity requests go
// straight to the response state, and an add to an empty side writes its
// level directly. An insert walks down from the worst level, shifting one
// level per cycle until it finds its place. A query walks the ask ladder
// one level per cycle with a registered 32x32 multiply, then runs a
// restoring divide, which is skipped when the asks cannot fill it. One
// request is in flight at a time; a finished response waits in the output
// register until it is taken, and only the next response, not the next
// request, waits behind it.
module order_book_slippage_engine #(
   parameter int MAX_LEVELS = obs_pkg::MAX_LEVELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] price, [63:32] quantity
   input  logic [obs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  logic [obs_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] best_bid, [63:32] best_ask, [96:64] spread, [129:97] mid_doubled,
   // [178:130] slippage, [183:179] zero
   output logic [obs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [2:0] status
   output logic [obs_pkg::STATUS_W-1:0]     rsp_tuser
);
   import obs_pkg::*;

   localparam int AW = $clog2(MAX_LEVELS);
   localparam int CW = $clog2(MAX_LEVELS + 1);

   state_type          state_ff, state_in;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [CW-1:0]      bid_cnt_ff, ask_cnt_ff;
   logic [PRICE_W-1:0] best_bid_ff, best_ask_ff;
   logic [AW-1:0]      idx_ff;
   logic               side_ask_ff;
   logic [QTY_W-1:0]   rem_ff;
   logic [ACC_W-1:0]   acc_ff, prod_ff;
   logic               pv_ff;
   status_type         status_ff;
   logic [SLIP_W-1:0]  quot_ff;
   logic               ok_ff;
   logic               rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   cmd_type            req_cmd;
   logic [PRICE_W-1:0] req_price;
   logic [QTY_W-1:0]   req_qty;
   logic               req_fire;
   logic               out_free;

   logic               bid_wr_en, ask_wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [LVL_W-1:0]   wr_data;
   logic [LVL_W-1:0]   bid_rd, ask_rd, rd_data;
   logic [PRICE_W-1:0] rd_price;
   logic [QTY_W-1:0]   rd_qty;
   logic               move;
   logic [QTY_W-1:0]   ex;
   logic               walk_last;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [PRICE_W-1:0] out_bb, out_ba;
   logic [WIDE_W-1:0]  out_spread, out_mid;
   logic [SLIP_W-1:0]  out_slip;

   assign req_cmd   = cmd_type'(req_tuser);
   assign req_price = req_tdata[PRICE_W-1:0];
   assign req_qty   = req_tdata[PRICE_W+QTY_W-1:PRICE_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   obs_ram #(.WIDTH(LVL_W), .DEPTH(MAX_LEVELS)) u_bid_ram (
      .clock   (clock),
      .wr_en   (bid_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (bid_rd)
   );

   obs_ram #(.WIDTH(LVL_W), .DEPTH(MAX_LEVELS)) u_ask_ram (
      .clock   (clock),
      .wr_en   (ask_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ask_rd)
   );

   obs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_data  = side_ask_ff ? ask_rd : bid_rd;
   assign rd_price = rd_data[LVL_W-1:QTY_W];
   assign rd_qty   = rd_data[QTY_W-1:0];
   // bids descend, asks ascend; equal prices stay ahead of the new level
   assign move      = side_ask_ff ? (price_ff < rd_price) : (price_ff > rd_price);
   assign ex        = (rem_ff < rd_qty) ? rem_ff : rd_qty;
   assign walk_last = (rem_ff == ex) || ((CW'(idx_ff) + 1'b1) == ask_cnt_ff);

   assign div_req.start    = (state_ff == S_Q_CHK) && (rem_ff == '0);
   assign div_req.weighted = acc_ff;
   assign div_req.divisor  = qty_ff;

   always_comb begin
      state_in  = state_ff;
      bid_wr_en = 1'b0;
      ask_wr_en = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = {price_ff, qty_ff};
      rd_addr   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_cmd)
                  CMD_CLEAR: state_in = S_RESP;
                  CMD_ADD_BID: begin
                     if (bid_cnt_ff == CW'(MAX_LEVELS)) state_in = S_RESP;
                     else if (bid_cnt_ff == '0)         state_in = S_INS_WR;
                     else                               state_in = S_INS_RD;
                  end
                  CMD_ADD_ASK: begin
                     if (ask_cnt_ff == CW'(MAX_LEVELS)) state_in = S_RESP;
                     else if (ask_cnt_ff == '0)         state_in = S_INS_WR;
                     else                               state_in = S_INS_RD;
                  end
                  CMD_QUERY: begin
                     if (bid_cnt_ff == '0 || ask_cnt_ff == '0 || req_qty == '0) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_Q_RD;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_INS_RD: state_in = S_INS_EV;
         S_INS_EV: begin
            rd_addr   = idx_ff - 1'b1;
            wr_addr   = idx_ff + 1'b1;
            bid_wr_en = !side_ask_ff;
            ask_wr_en = side_ask_ff;
            if (move) begin
               wr_data = rd_data;
               if (idx_ff == '0) state_in = S_INS_WR;
            end else begin
               state_in = S_RESP;
            end
         end
         S_INS_WR: begin
            bid_wr_en = !side_ask_ff;
            ask_wr_en = side_ask_ff;
            state_in  = S_RESP;
         end
         S_Q_RD: state_in = S_Q_EV;
         S_Q_EV: begin
            rd_addr = idx_ff + 1'b1;
            if (walk_last) state_in = S_Q_END;
         end
         S_Q_END: state_in = S_Q_CHK;
         S_Q_CHK: state_in = (rem_ff == '0) ? S_DIV : S_RESP;
         S_DIV:   if (div_rsp.done) state_in = S_RESP;
         S_RESP:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      out_bb     = (bid_cnt_ff != '0) ? best_bid_ff : '0;
      out_ba     = (ask_cnt_ff != '0) ? best_ask_ff : '0;
      out_spread = {1'b0, out_ba} - {1'b0, out_bb};
      out_mid    = {1'b0, out_ba} + {1'b0, out_bb};
      out_slip   = ok_ff ? (quot_ff - {1'b0, out_mid, 15'b0}) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bid_cnt_ff   <= '0;
         ask_cnt_ff   <= '0;
         pv_ff        <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;
         if (pv_ff) acc_ff <= acc_ff + prod_ff;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  price_ff    <= req_price;
                  qty_ff      <= req_qty;
                  ok_ff       <= 1'b0;
                  side_ask_ff <= (req_cmd != CMD_ADD_BID);
                  rem_ff      <= req_qty;
                  acc_ff      <= '0;
                  unique case (req_cmd)
                     CMD_CLEAR: begin
                        bid_cnt_ff <= '0;
                        ask_cnt_ff <= '0;
                        status_ff  <= ST_OK;
                        idx_ff     <= '0;
                     end
                     CMD_ADD_BID: begin
                        status_ff <= (bid_cnt_ff == CW'(MAX_LEVELS)) ? ST_FULL : ST_OK;
                        // start at the worst level, or at the top of an empty side
                        idx_ff <= (bid_cnt_ff == '0) ? '0 : AW'(bid_cnt_ff - 1'b1);
                     end
                     CMD_ADD_ASK: begin
                        status_ff <= (ask_cnt_ff == CW'(MAX_LEVELS)) ? ST_FULL : ST_OK;
                        idx_ff <= (ask_cnt_ff == '0) ? '0 : AW'(ask_cnt_ff - 1'b1);
                     end
                     CMD_QUERY: begin
                        idx_ff <= '0;
                        if (bid_cnt_ff == '0 || ask_cnt_ff == '0) status_ff <= ST_EMPTY;
                        else if (req_qty == '0)                   status_ff <= ST_ZERO_QTY;
                        else                                      status_ff <= ST_OK;
                     end
                     default: begin
                        status_ff <= ST_OK;
                        idx_ff    <= '0;
                     end
                  endcase
               end
            end
            S_INS_EV: begin
               if (move) begin
                  if (idx_ff != '0) idx_ff <= idx_ff - 1'b1;
               end else begin
                  // new level lands below an existing one: best is unchanged
                  if (side_ask_ff) ask_cnt_ff <= ask_cnt_ff + 1'b1;
                  else             bid_cnt_ff <= bid_cnt_ff + 1'b1;
               end
            end
            S_INS_WR: begin
               if (side_ask_ff) begin
                  ask_cnt_ff  <= ask_cnt_ff + 1'b1;
                  best_ask_ff <= price_ff;
               end else begin
                  bid_cnt_ff  <= bid_cnt_ff + 1'b1;
                  best_bid_ff <= price_ff;
               end
            end
            S_Q_EV: begin
               prod_ff <= ex * rd_price;
               pv_ff   <= 1'b1;
               rem_ff  <= rem_ff - ex;
               idx_ff  <= idx_ff + 1'b1;
            end
            S_Q_END: pv_ff <= 1'b0;
            S_Q_CHK: if (rem_ff != '0) status_ff <= ST_SHORT;
            S_DIV: begin
               if (div_rsp.done) begin
                  quot_ff <= div_rsp.quotient;
                  ok_ff   <= 1'b1;
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_data_ff   <= {{(RSP_DATA_W-RSP_USED_W){1'b0}}, out_slip, out_mid,
                                    out_spread, out_ba, out_bb};
               end
            end
            default: pv_ff <= pv_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

[hdl/obs_chk.sv]
// ----------------------------------------------------------------------------
// Order book slippage engine checker
// Port-level assertions on the request and response streams, bound to the top level.
// ----------------------------------------------------------------------------
module obs_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [obs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [obs_pkg::STATUS_W-1:0]    rsp_tuser
);
   import obs_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // drop slippage on every non-ok status
   a_slip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[178:130] == '0)
      else $error("slippage set with non-ok status");

   a_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[96:64] ==
         ({1'b0, rsp_tdata[63:32]} - {1'b0, rsp_tdata[31:0]}) &&
         rsp_tdata[129:97] == ({1'b0, rsp_tdata[63:32]} + {1'b0, rsp_tdata[31:0]}))
      else $error("spread or mid disagrees with best prices");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

endmodule

bind order_book_slippage_engine obs_chk u_obs_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
